// ----- hdl/bls_pkg.sv -----
`timescale 1ns / 1ps

package bls_pkg;

   // Default coordinate width of the line endpoints and of the emitted pixels.
   localparam int COORD_BITS_DEF = 12;

   // Request actions.
   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_STEP = 1'b1
   } action_type;

endpackage

// ----- hdl/bresenham_line_stepper_core.sv -----
`timescale 1ns / 1ps
// A pixel beat appears on the rsp_ channel in the cycle after the request beat that produced it is taken.
// Throughput: one request beat per clock; req_ready drops only while a result beat waits.
// The output register is the only stage, so a taken result frees it in the same cycle.
// Reset (synchronous, active high) clears the line state and leaves no line active.

module bresenham_line_stepper_core #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_stop_x,
   input  logic signed [COORD_BITS-1:0] req_stop_y,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last
);
   import bls_pkg::*;

   // Endpoint differences need one more bit than a coordinate; the decision
   // term and its increments are twice a difference, so two more.
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int DEC_BITS  = COORD_BITS + 2;

   // Line state.
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic signed [DEC_BITS-1:0]   decision_ff, decision_in;
   logic signed [DEC_BITS-1:0]   inc_straight_ff, inc_straight_in;
   logic signed [DEC_BITS-1:0]   inc_diagonal_ff, inc_diagonal_in;
   logic                         minor_negative_ff, minor_negative_in;
   logic                         y_is_major_ff, y_is_major_in;
   logic                         active_ff, active_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_pixel_x_ff, rsp_pixel_x_in;
   logic signed [COORD_BITS-1:0] rsp_pixel_y_ff, rsp_pixel_y_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic req_beat;
   logic emit;
   logic last;

   // Load path signals.
   logic signed [DIFF_BITS-1:0]  diff_x, diff_y;
   logic signed [DIFF_BITS-1:0]  abs_dx, abs_dy;
   logic signed [DIFF_BITS-1:0]  d_major, d_minor;
   logic signed [DEC_BITS-1:0]   d_major_w, d_minor_w;
   logic                         load_y_major;
   logic                         swap_ends;
   logic signed [COORD_BITS-1:0] first_x, first_y, final_x, final_y;

   // Step path signals.
   logic                         move_minor;
   logic signed [COORD_BITS-1:0] minor_step;
   logic signed [COORD_BITS-1:0] step_x, step_y;
   logic signed [COORD_BITS-1:0] step_major;

   // The output register accepts a new beat whenever it is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;

   // Endpoint geometry for a load beat. The differences are taken at one bit
   // wider than a coordinate, so they never wrap.
   always_comb begin
      diff_x = DIFF_BITS'(req_start_x) - DIFF_BITS'(req_stop_x);
      diff_y = DIFF_BITS'(req_start_y) - DIFF_BITS'(req_stop_y);
      abs_dx = diff_x[DIFF_BITS-1] ? -diff_x : diff_x;
      abs_dy = diff_y[DIFF_BITS-1] ? -diff_y : diff_y;

      // A tie in the absolute differences makes x the major axis.
      load_y_major = abs_dy > abs_dx;
      d_major      = load_y_major ? abs_dy : abs_dx;
      d_minor      = load_y_major ? abs_dx : abs_dy;

      // Start at the endpoint whose major coordinate is smaller.
      swap_ends = load_y_major ? (diff_y > 0) : (diff_x > 0);
      first_x   = swap_ends ? req_stop_x  : req_start_x;
      first_y   = swap_ends ? req_stop_y  : req_start_y;
      final_x   = swap_ends ? req_start_x : req_stop_x;
      final_y   = swap_ends ? req_start_y : req_stop_y;

      d_major_w = DEC_BITS'(d_major);
      d_minor_w = DEC_BITS'(d_minor);
   end

   // One Bresenham step on the registered line state: the major coordinate
   // always advances, the minor one moves when the decision term is not negative.
   always_comb begin
      move_minor = !decision_ff[DEC_BITS-1];
      minor_step = minor_negative_ff ? -COORD_BITS'(1) : COORD_BITS'(1);
      if (y_is_major_ff) begin
         step_y = cur_y_ff + COORD_BITS'(1);
         step_x = move_minor ? cur_x_ff + minor_step : cur_x_ff;
         step_major = step_y;
      end else begin
         step_x = cur_x_ff + COORD_BITS'(1);
         step_y = move_minor ? cur_y_ff + minor_step : cur_y_ff;
         step_major = step_x;
      end
   end

   // Next state and next result.
   always_comb begin
      cur_x_in          = cur_x_ff;
      cur_y_in          = cur_y_ff;
      major_end_in      = major_end_ff;
      decision_in       = decision_ff;
      inc_straight_in   = inc_straight_ff;
      inc_diagonal_in   = inc_diagonal_ff;
      minor_negative_in = minor_negative_ff;
      y_is_major_in     = y_is_major_ff;
      active_in         = active_ff;
      emit              = 1'b0;
      last              = 1'b0;

      if (req_beat) begin
         unique case (action_type'(req_action))
            ACTION_LOAD: begin
               // A load always restarts the block, dropping any line in progress.
               emit              = 1'b1;
               last              = (d_major == '0);
               cur_x_in          = first_x;
               cur_y_in          = first_y;
               y_is_major_in     = load_y_major;
               major_end_in      = load_y_major ? final_y : final_x;
               minor_negative_in = load_y_major ? (final_x < first_x) : (final_y < first_y);
               decision_in       = (d_minor_w <<< 1) - d_major_w;
               inc_straight_in   = d_minor_w <<< 1;
               inc_diagonal_in   = (d_minor_w - d_major_w) <<< 1;
            end
            ACTION_STEP: begin
               // A step with no line in progress is taken and yields no pixel.
               if (active_ff) begin
                  emit        = 1'b1;
                  last        = (step_major == major_end_ff);
                  cur_x_in    = step_x;
                  cur_y_in    = step_y;
                  decision_in = decision_ff + (move_minor ? inc_diagonal_ff : inc_straight_ff);
               end
            end
            default: begin
            end
         endcase
         if (emit) begin
            active_in = !last;
         end
      end

      rsp_valid_in   = emit || (rsp_valid_ff && !rsp_ready);
      rsp_pixel_x_in = emit ? cur_x_in : rsp_pixel_x_ff;
      rsp_pixel_y_in = emit ? cur_y_in : rsp_pixel_y_ff;
      rsp_last_in    = emit ? last     : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff          <= '0;
         cur_y_ff          <= '0;
         major_end_ff      <= '0;
         decision_ff       <= '0;
         inc_straight_ff   <= '0;
         inc_diagonal_ff   <= '0;
         minor_negative_ff <= 1'b0;
         y_is_major_ff     <= 1'b0;
         active_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cur_x_ff          <= cur_x_in;
         cur_y_ff          <= cur_y_in;
         major_end_ff      <= major_end_in;
         decision_ff       <= decision_in;
         inc_straight_ff   <= inc_straight_in;
         inc_diagonal_ff   <= inc_diagonal_in;
         minor_negative_ff <= minor_negative_in;
         y_is_major_ff     <= y_is_major_in;
         active_ff         <= active_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload holds its value while a beat waits, so it needs no reset.
   always_ff @(posedge clock) begin
      rsp_pixel_x_ff <= rsp_pixel_x_in;
      rsp_pixel_y_ff <= rsp_pixel_y_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_x = rsp_pixel_x_ff;
   assign rsp_pixel_y = rsp_pixel_y_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ----- hdl/bls_checker.sv -----
`timescale 1ns / 1ps

module bls_checker #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_action,
   input logic signed [COORD_BITS-1:0] req_start_x,
   input logic signed [COORD_BITS-1:0] req_start_y,
   input logic signed [COORD_BITS-1:0] req_stop_x,
   input logic signed [COORD_BITS-1:0] req_stop_y,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic                         rsp_last
);
   import bls_pkg::*;

   // Reset leaves no result beat pending.
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat pending after reset");

   // With no result pending the block must take a request beat.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while output register is empty");

   // Every accepted load produces a pixel beat on the next cycle.
   a_load_emits: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACTION_LOAD)) |=> rsp_valid)
      else $error("load beat produced no pixel");

   // A stalled result beat holds its payload.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_last)))
      else $error("stalled result beat changed");

endmodule

bind bresenham_line_stepper_core bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_action  (req_action),
   .req_start_x (req_start_x),
   .req_start_y (req_start_y),
   .req_stop_x  (req_stop_x),
   .req_stop_y  (req_stop_y),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_pixel_x (rsp_pixel_x),
   .rsp_pixel_y (rsp_pixel_y),
   .rsp_last    (rsp_last)
);
